@@ rtl/gca_pkg.sv @@
// shared constants, beat layouts and helpers for the greedy capacitated assignment block
package gca_pkg;

  // table and counter sizing
  localparam int FACILITIES  = 64;
  localparam int MAX_CLIENTS = 4096;
  localparam int FAC_AW      = (FACILITIES > 1) ? $clog2(FACILITIES) : 1;

  // field widths
  localparam int FAC_W  = 6;
  localparam int COST_W = 32;
  localparam int CAP_W  = 24;
  localparam int SUM_W  = 33;
  localparam int TOT_W  = 48;
  localparam int CLI_W  = 12;

  // stream widths, padded to whole bytes
  localparam int IN_FIELDS_W  = FAC_W + COST_W + CAP_W + COST_W + CAP_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = CLI_W + FAC_W + SUM_W + TOT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // beat kind carried on tuser
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_COST = 1'b1
  } op_t;

  // input beat payload, facility in the lowest bits
  typedef struct packed {
    logic [CAP_W-1:0]  demand;
    logic [COST_W-1:0] assign_cost;
    logic [CAP_W-1:0]  capacity;
    logic [COST_W-1:0] open_cost;
    logic [FAC_W-1:0]  facility;
  } in_beat_t;

  // result beat payload, client index in the lowest bits
  typedef struct packed {
    logic [TOT_W-1:0] total_cost;
    logic [SUM_W-1:0] client_cost;
    logic [FAC_W-1:0] chosen_facility;
    logic [CLI_W-1:0] client_index;
  } out_beat_t;

  // one queued result
  typedef struct packed {
    out_beat_t data;
    logic      no_fit;
  } result_t;

  // facility index maps onto a table entry
  function automatic logic fac_in_range(input logic [FAC_W-1:0] f);
    return 32'(f) < FACILITIES;
  endfunction

  function automatic logic [FAC_AW-1:0] fac_addr(input logic [FAC_W-1:0] f);
    return FAC_AW'(f);
  endfunction

endpackage

@@ rtl/greedy_capacitated_assignment.sv @@
// greedy capacitated assignment: facility tables in memory, row scan, result queue
//
// Load beats (tuser 0) write one facility's opening cost and capacity and clear the
// running total and client count; cost beats (tuser 1) stream one client's row of
// assignment costs in ascending facility order, tlast on the final element. The
// block takes one beat per clock while in_tready is high, back to back across rows
// and loads. Each beat passes a read stage (opening cost and capacity memories,
// registered read) and a compare stage, and a row-end or load beat commits its
// table write and total in a third stage; writes still in flight are forwarded to
// the compare stage, so a row may follow its predecessor directly. A result is
// pushed from the commit stage into a four-entry queue; in_tready drops only
// when the queue and the beats in flight could fill it. Tables hold no reset value
// and need no clearing pass: entries must be loaded before a row reads them.
module greedy_capacitated_assignment (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // facility, open_cost, capacity, assign_cost, demand, zero pad
  input  logic [gca_pkg::IN_TDATA_W-1:0] in_tdata,
  // op
  input  logic                          in_tuser,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // client_index, chosen_facility, client_cost, total_cost, zero pad
  output logic [gca_pkg::OUT_TDATA_W-1:0] out_tdata,
  // no_fit
  output logic                          out_tuser
);
  import gca_pkg::*;

  // facility tables
  logic [COST_W-1:0] oc_mem  [FACILITIES];
  logic [CAP_W-1:0]  cap_mem [FACILITIES];
  logic [COST_W-1:0] oc_rd_r;
  logic [CAP_W-1:0]  cap_rd_r;

  // input beat
  in_beat_t          in_beat;
  logic              in_fire;

  // compare stage
  logic              v1_r;
  op_t               op1_r;
  in_beat_t          beat1_r;
  logic              last1_r;
  logic [FAC_AW-1:0] a1;
  logic [COST_W-1:0] oc1;
  logic [CAP_W-1:0]  cap1;
  logic [SUM_W-1:0]  val1;
  logic              cand1;
  logic              res1;

  // row state
  logic              best_found_r, best_found_nxt;
  logic [SUM_W-1:0]  best_cost_r, best_cost_nxt;
  logic [FAC_W-1:0]  best_fac_r, best_fac_nxt;
  logic [CAP_W-1:0]  best_cap_r, best_cap_nxt;

  // commit stage
  logic              v2_r;
  op_t               op2_r;
  in_beat_t          beat2_r;
  logic              last2_r;
  logic              found2_r;
  logic [SUM_W-1:0]  bcost2_r;
  logic [FAC_W-1:0]  bfac2_r;
  logic [CAP_W-1:0]  bcap2_r;
  logic              res2;

  // table write and its forwarding copy
  logic              we;
  logic [FAC_AW-1:0] wa;
  logic [COST_W-1:0] wd_oc;
  logic [CAP_W-1:0]  wd_cap;
  logic              wb_v_r;
  logic [FAC_AW-1:0] wb_a_r;
  logic [COST_W-1:0] wb_oc_r;
  logic [CAP_W-1:0]  wb_cap_r;

  // totals
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [CLI_W-1:0]  cnt_r, cnt_nxt;
  logic [TOT_W:0]    sum2;
  logic [TOT_W-1:0]  sat2;
  logic [CLI_W:0]    cnt_inc;

  // result queue
  result_t           q_mem [Q_DEPTH];
  logic [Q_AW-1:0]   q_wp_r, q_rp_r;
  logic [Q_CW-1:0]   q_cnt_r;
  logic [Q_CW+1:0]   q_need;
  logic              push, pop;
  result_t           push_data;
  result_t           q_head;

  assign in_beat = in_tdata[IN_FIELDS_W-1:0];
  assign in_fire = in_tvalid && in_tready;

  // memories: write from commit stage, read every cycle at the incoming address
  always_ff @(posedge clk) begin
    if (we) begin
      oc_mem[wa]  <= wd_oc;
      cap_mem[wa] <= wd_cap;
    end
    oc_rd_r  <= oc_mem[fac_addr(in_beat.facility)];
    cap_rd_r <= cap_mem[fac_addr(in_beat.facility)];
  end

  // read data with forwarding from the current write and the previous cycle's write
  always_comb begin
    a1   = fac_addr(beat1_r.facility);
    oc1  = oc_rd_r;
    cap1 = cap_rd_r;
    if (we && wa == a1) begin
      oc1  = wd_oc;
      cap1 = wd_cap;
    end else if (wb_v_r && wb_a_r == a1) begin
      oc1  = wb_oc_r;
      cap1 = wb_cap_r;
    end
  end

  // candidate compare; ties keep the earlier facility
  always_comb begin
    val1  = {1'b0, oc1} + {1'b0, beat1_r.assign_cost};
    cand1 = v1_r && (op1_r == OP_COST) && fac_in_range(beat1_r.facility) &&
            (cap1 >= beat1_r.demand) && (!best_found_r || val1 < best_cost_r);
    best_found_nxt = best_found_r;
    best_cost_nxt  = best_cost_r;
    best_fac_nxt   = best_fac_r;
    best_cap_nxt   = best_cap_r;
    if (cand1) begin
      best_found_nxt = 1'b1;
      best_cost_nxt  = val1;
      best_fac_nxt   = beat1_r.facility;
      best_cap_nxt   = cap1;
    end
  end

  assign res1 = v1_r && (op1_r == OP_COST) && last1_r;
  assign res2 = v2_r && (op2_r == OP_COST) && last2_r;

  // compare stage and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      best_found_r <= 1'b0;
      best_cost_r  <= '0;
      best_fac_r   <= '0;
    end else begin
      v1_r <= in_fire;
      if (v1_r && (op1_r == OP_LOAD || last1_r)) begin
        best_found_r <= 1'b0;
        best_cost_r  <= '0;
        best_fac_r   <= '0;
      end else begin
        best_found_r <= best_found_nxt;
        best_cost_r  <= best_cost_nxt;
        best_fac_r   <= best_fac_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op1_r   <= op_t'(in_tuser);
      beat1_r <= in_beat;
      last1_r <= in_tlast;
    end
    best_cap_r <= best_cap_nxt;
    op2_r      <= op1_r;
    beat2_r    <= beat1_r;
    last2_r    <= last1_r;
    found2_r   <= best_found_nxt;
    bcost2_r   <= best_cost_nxt;
    bfac2_r    <= best_fac_nxt;
    bcap2_r    <= best_cap_nxt;
    wb_a_r     <= wa;
    wb_oc_r    <= wd_oc;
    wb_cap_r   <= wd_cap;
  end

  // table write: facility load, or row-end update of the chosen facility
  always_comb begin
    we     = 1'b0;
    wa     = fac_addr(beat2_r.facility);
    wd_oc  = beat2_r.open_cost;
    wd_cap = beat2_r.capacity;
    if (v2_r) begin
      if (op2_r == OP_LOAD) begin
        we = fac_in_range(beat2_r.facility);
      end else if (last2_r && found2_r) begin
        we     = 1'b1;
        wa     = fac_addr(bfac2_r);
        wd_oc  = '0;
        wd_cap = bcap2_r - beat2_r.demand;
      end
    end
  end

  // saturating total and wrapping client count
  always_comb begin
    sum2    = {1'b0, total_r} + (TOT_W+1)'(bcost2_r);
    sat2    = sum2[TOT_W] ? {TOT_W{1'b1}} : sum2[TOT_W-1:0];
    cnt_inc = {1'b0, cnt_r} + (CLI_W+1)'(1);
    total_nxt = total_r;
    cnt_nxt   = cnt_r;
    if (v2_r && op2_r == OP_LOAD) begin
      total_nxt = '0;
      cnt_nxt   = '0;
    end else if (res2 && found2_r) begin
      total_nxt = sat2;
      cnt_nxt   = (cnt_inc >= (CLI_W+1)'(MAX_CLIENTS)) ? '0 : cnt_inc[CLI_W-1:0];
    end
    push_data.data.client_index    = cnt_r;
    push_data.data.chosen_facility = found2_r ? bfac2_r : '0;
    push_data.data.client_cost     = found2_r ? bcost2_r : '0;
    push_data.data.total_cost      = found2_r ? sat2 : total_r;
    push_data.no_fit               = !found2_r;
  end

  // commit stage control and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      wb_v_r  <= 1'b0;
      total_r <= '0;
      cnt_r   <= '0;
    end else begin
      v2_r    <= v1_r;
      wb_v_r  <= we;
      total_r <= total_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // result queue; room is reserved for every row-end beat in flight
  assign push    = res2;
  assign pop     = out_tvalid && out_tready;
  assign q_need  = (Q_CW+2)'(q_cnt_r) + (Q_CW+2)'(res1) + (Q_CW+2)'(res2);
  assign in_tready = q_need < (Q_CW+2)'(Q_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (push) begin
        q_wp_r <= q_wp_r + Q_AW'(1);
      end
      if (pop) begin
        q_rp_r <= q_rp_r + Q_AW'(1);
      end
      case ({push, pop})
        2'b10:   q_cnt_r <= q_cnt_r + Q_CW'(1);
        2'b01:   q_cnt_r <= q_cnt_r - Q_CW'(1);
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

  // output beat
  assign q_head     = q_mem[q_rp_r];
  assign out_tvalid = q_cnt_r != '0;
  assign out_tdata  = OUT_TDATA_W'(q_head.data);
  assign out_tuser  = q_head.no_fit;

  // queue never overruns its storage
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= Q_CW'(Q_DEPTH))
    else $error("result queue overrun");

  // a committed load leaves total and client count at zero
  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && op2_r == OP_LOAD) |=> (total_r == '0 && cnt_r == '0))
    else $error("load did not clear totals");

  // row state is gone after a load or a row end
  a_row_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && (op1_r == OP_LOAD || last1_r)) |=> !best_found_r)
    else $error("row state survived row end");

  // a no-fit result carries no facility and no cost
  a_no_fit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (q_head.data.client_cost == '0 && q_head.data.chosen_facility == '0))
    else $error("no-fit result with nonzero cost");

endmodule
